// ===== rtl/mwies_pkg.sv =====
// Package for the masked window image error score block.
// Holds field widths, register indexes and the shared struct types.
// No dependencies.
package mwies_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 12;
    localparam int CFG_W   = 13;
    localparam int ERR_W   = 16;
    localparam int ACC_W   = 40;
    localparam int CNT_W   = 25;
    localparam int MEAN_W  = 24;
    localparam int DIM_W   = 17;
    localparam int IDX_W   = 3;

    // Largest image dimension; the right and bottom bounds are clipped to it
    localparam logic [DIM_W-1:0] MAX_DIM = 17'd4096;

    localparam logic [PIX_W-1:0] PIX_NO_DATA = 8'd255;
    localparam logic [PIX_W-1:0] WET_LIMIT   = 8'd1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_WINDOW_LEFT   = 3'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_RIGHT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW_TOP    = 3'd2;
    localparam logic [IDX_W-1:0] REG_WINDOW_BOTTOM = 3'd3;
    localparam logic [IDX_W-1:0] REG_BINARY_MODE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_THREAT_MODE   = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0] window_left;
        logic [CFG_W-1:0] window_right;
        logic [CFG_W-1:0] window_top;
        logic [CFG_W-1:0] window_bottom;
        logic             binary_mode;
        logic             threat_mode;
    } cfg_t;

    typedef struct packed {
        logic [ACC_W-1:0] error_sum;
        logic [CNT_W-1:0] pixel_count;
    } totals_t;

    typedef struct packed {
        logic              done;
        logic [MEAN_W-1:0] mean;
    } quot_t;

endpackage

// ===== rtl/mwies_if.sv =====
// Stream interfaces for pixel words in and result words out.
// Depends on mwies_pkg for field widths.
interface mwies_pixel_if;
    import mwies_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   predicted_pixel;
    logic [PIX_W-1:0]   true_pixel;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               frame_end;

    modport source (output valid, predicted_pixel, true_pixel, column, row, frame_end,
                    input ready);
    modport sink   (input valid, predicted_pixel, true_pixel, column, row, frame_end,
                    output ready);
endinterface

interface mwies_result_if;
    import mwies_pkg::*;
    logic              valid;
    logic              ready;
    logic [MEAN_W-1:0] mean_score;
    logic [ACC_W-1:0]  error_total;
    logic [CNT_W-1:0]  counted_pixels;
    logic              window_empty;

    modport source (output valid, mean_score, error_total, counted_pixels, window_empty,
                    input ready);
    modport sink   (input valid, mean_score, error_total, counted_pixels, window_empty,
                    output ready);
endinterface

// ===== rtl/mwies_score.sv =====
// Per-pixel scoring and frame accumulation (error sum and pixel count).
// Depends on mwies_pkg.
module mwies_score
    import mwies_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               take,
    input  logic               last,
    input  logic [PIX_W-1:0]   predicted_pixel,
    input  logic [PIX_W-1:0]   true_pixel,
    input  logic [COORD_W-1:0] column,
    input  logic [COORD_W-1:0] row,
    output totals_t            totals
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [DIM_W-1:0] right_eff, bottom_eff;
    logic             in_window, counted, wet_a, wet_b;
    logic [PIX_W-1:0] a, diff;
    logic [ERR_W-1:0] err;
    logic [ACC_W:0]   sum;

    always_comb
    begin
        right_eff  = (DIM_W'(cfg.window_right) > MAX_DIM) ? MAX_DIM : DIM_W'(cfg.window_right);
        bottom_eff = (DIM_W'(cfg.window_bottom) > MAX_DIM) ? MAX_DIM
                                                          : DIM_W'(cfg.window_bottom);
        in_window = (CFG_W'(column) >= cfg.window_left) && (DIM_W'(column) < right_eff) &&
                    (CFG_W'(row) >= cfg.window_top) && (DIM_W'(row) < bottom_eff);

        a     = (predicted_pixel == PIX_NO_DATA) ? '0 : predicted_pixel;
        wet_a = a > WET_LIMIT;
        wet_b = true_pixel > WET_LIMIT;
        diff  = (a > true_pixel) ? (a - true_pixel) : (true_pixel - a);

        counted = in_window && (true_pixel != PIX_NO_DATA);
        if (cfg.binary_mode)
        begin
            err = ERR_W'(wet_a ^ wet_b);
            // threat mode: skip pairs that are both dry
            if (cfg.threat_mode && !wet_a && !wet_b)
                counted = 1'b0;
        end
        else
        begin
            err = ERR_W'(diff) * ERR_W'(diff);
        end

        sum      = {1'b0, acc_reg} + (ACC_W + 1)'(err);
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (counted)
        begin
            acc_next = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
            if (cnt_reg != '1)
                cnt_next = cnt_reg + 1'b1;
        end
    end

    assign totals.error_sum   = acc_next;
    assign totals.pixel_count = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (take)
        begin
            acc_reg <= last ? '0 : acc_next;
            cnt_reg <= last ? '0 : cnt_next;
        end
    end

endmodule

// ===== rtl/mwies_div.sv =====
// Shared restoring divider, one quotient bit per cycle, saturating quotient.
// Forms (sum << FRACTION_BITS) + count/2 and divides it by count. Depends on mwies_pkg.
module mwies_div
    import mwies_pkg::*;
#(
    parameter int FRACTION_BITS = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  totals_t operands,
    output quot_t   result
);

    localparam int NUM_W  = ACC_W + FRACTION_BITS + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  den_reg, den_next;
    logic [MEAN_W-1:0] q_reg, q_next;
    logic              ovf_reg, ovf_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [CNT_W:0] shifted, trial;
    logic           fits;

    always_comb
    begin
        shifted = {rem_reg, num_reg[NUM_W-1]};
        trial   = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};

        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            num_next  = (NUM_W'(operands.error_sum) << FRACTION_BITS) +
                        NUM_W'(operands.pixel_count >> 1);
            den_next  = operands.pixel_count;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            step_next = STEP_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next  = num_reg << 1;
            rem_next  = fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
            // a bit shifted out of the top means the mean saturates
            ovf_next  = ovf_reg | q_reg[MEAN_W-1];
            q_next    = {q_reg[MEAN_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign result.done = done_reg;
    assign result.mean = ovf_reg ? '1 : q_reg;

endmodule

// ===== rtl/masked_window_image_error_score.sv =====
// Masked window image error score: scores a raster stream of pixel pairs over a
// rectangular window and gives one result word per frame. Pixel words without
// frame_end are taken one per cycle. The word that carries frame_end closes the
// frame: the block then drops ready while the shared divider forms the mean, one
// quotient bit per cycle, and then while the result is handed to the output
// register; an empty window skips the divider. Hold a result word in the output
// register until it is taken; pixel words of the next frame keep flowing
// meanwhile. Configuration writes take effect at once and should be made
// between frames. Depends on mwies_pkg, mwies_if, mwies_score and mwies_div.
module masked_window_image_error_score
    import mwies_pkg::*;
#(
    parameter int FRACTION_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    mwies_pixel_if.sink          pix,
    mwies_result_if.source       res,
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_DIVIDE  = 3'b010,
        ST_DELIVER = 3'b100
    } state_t;

    state_t state_reg, state_next;
    cfg_t   cfg_reg;

    totals_t totals;
    quot_t   quot;
    logic    take, frame_close, div_start;

    // Snapshot of the closed frame, held until the result word is loaded
    logic [ACC_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              empty_reg;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [MEAN_W-1:0] out_mean_reg;
    logic [ACC_W-1:0]  out_sum_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic              out_empty_reg;
    logic              load_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_left   <= '0;
            cfg_reg.window_right  <= CFG_W'(MAX_DIM);
            cfg_reg.window_top    <= '0;
            cfg_reg.window_bottom <= CFG_W'(MAX_DIM);
            cfg_reg.binary_mode   <= 1'b0;
            cfg_reg.threat_mode   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_LEFT:   cfg_reg.window_left   <= cfg_data;
                REG_WINDOW_RIGHT:  cfg_reg.window_right  <= cfg_data;
                REG_WINDOW_TOP:    cfg_reg.window_top    <= cfg_data;
                REG_WINDOW_BOTTOM: cfg_reg.window_bottom <= cfg_data;
                REG_BINARY_MODE:   cfg_reg.binary_mode   <= cfg_data[0];
                REG_THREAT_MODE:   cfg_reg.threat_mode   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign pix.ready   = (state_reg == ST_IDLE);
    assign take        = pix.valid && pix.ready;
    assign frame_close = take && pix.frame_end;
    // an empty window needs no division
    assign div_start   = frame_close && (totals.pixel_count != '0);

    mwies_score u_score (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .take            (take),
        .last            (pix.frame_end),
        .predicted_pixel (pix.predicted_pixel),
        .true_pixel      (pix.true_pixel),
        .column          (pix.column),
        .row             (pix.row),
        .totals          (totals)
    );

    mwies_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .operands (totals),
        .result   (quot)
    );

    // Sequencer: idle, wait for the divider, deliver to the output register
    assign load_out = (state_reg == ST_DELIVER) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (div_start)
                    state_next = ST_DIVIDE;
                else if (frame_close)
                    state_next = ST_DELIVER;
            end
            ST_DIVIDE:
            begin
                if (quot.done)
                    state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the closed frame's totals
    always_ff @(posedge clk)
    begin
        if (frame_close)
        begin
            sum_reg   <= totals.error_sum;
            cnt_reg   <= totals.pixel_count;
            empty_reg <= (totals.pixel_count == '0);
        end
    end

    // Output register: load on delivery, drop valid once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.ready)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_mean_reg  <= empty_reg ? '0 : quot.mean;
            out_sum_reg   <= sum_reg;
            out_cnt_reg   <= cnt_reg;
            out_empty_reg <= empty_reg;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.mean_score     = out_mean_reg;
    assign res.error_total    = out_sum_reg;
    assign res.counted_pixels = out_cnt_reg;
    assign res.window_empty   = out_empty_reg;

endmodule

// ===== rtl/mwies_checker.sv =====
// Port-level checks for the masked window image error score block.
// Depends on mwies_pkg; bound to masked_window_image_error_score below.
module mwies_checker
    import mwies_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              pix_valid,
    input logic              pix_ready,
    input logic              pix_frame_end,
    input logic              res_valid,
    input logic              res_ready,
    input logic [MEAN_W-1:0] res_mean_score,
    input logic [ACC_W-1:0]  res_error_total,
    input logic [CNT_W-1:0]  res_counted_pixels,
    input logic              res_window_empty
);

    // a stalled result word holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_mean_score) &&
        $stable(res_error_total) && $stable(res_counted_pixels))
        else $error("result word changed while stalled");

    // closing a frame stalls the pixel stream in the cycle after it
    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && pix_frame_end |=> !pix_ready)
        else $error("pixel word taken right after frame end");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_window_empty |->
        res_counted_pixels == '0 && res_error_total == '0 && res_mean_score == '0)
        else $error("empty window with non-zero fields");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_window_empty |-> res_counted_pixels != '0)
        else $error("non-empty result with zero count");

endmodule

bind masked_window_image_error_score mwies_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .pix_valid          (pix.valid),
    .pix_ready          (pix.ready),
    .pix_frame_end      (pix.frame_end),
    .res_valid          (res.valid),
    .res_ready          (res.ready),
    .res_mean_score     (res.mean_score),
    .res_error_total    (res.error_total),
    .res_counted_pixels (res.counted_pixels),
    .res_window_empty   (res.window_empty)
);
